// ===== hdl/tsc_pkg.sv =====
// Package for the timestamp counter: widths, request and register codes,
// state type and the structs that pass between the top level and the divider.
// No dependencies.
package tsc_pkg;

   // Width of the free-running counter (16 to 64).
   localparam int COUNT_BITS   = 32;
   localparam int CNT_EXT_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   // Conversion arithmetic: 32-bit count times a 24-bit scale over a 32-bit rate.
   localparam int VALUE_BITS    = 32;
   localparam int SCALE_BITS    = 24;
   localparam int DIVIDEND_BITS = VALUE_BITS + SCALE_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIVIDEND_BITS);

   localparam logic [SCALE_BITS-1:0] PER_SEC_US   = SCALE_BITS'(1000000);
   localparam logic [SCALE_BITS-1:0] PER_SEC_US10 = SCALE_BITS'(10000000);

   // Request codes.
   localparam int REQ_BITS = 3;
   localparam logic [REQ_BITS-1:0] REQ_TICK          = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_READ_COUNT    = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_ELAPSED       = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_COUNT_US      = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_COUNT_US10    = 3'd4;
   localparam logic [REQ_BITS-1:0] REQ_ELAPSED_US    = 3'd5;
   localparam logic [REQ_BITS-1:0] REQ_ELAPSED_US10  = 3'd6;

   // Register indexes.
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOCK_HZ    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RUN_IN_IDLE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } tsc_state_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [VALUE_BITS-1:0]    divisor;
   } tsc_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] value;
      logic                  saturated;
   } tsc_div_rsp_type;

endpackage

// ===== hdl/tsc_if.sv =====
// Channel interfaces of the timestamp counter: request, result and register write.
// Depends on tsc_pkg.
interface tsc_req_if import tsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_BITS-1:0]   req_type;
   logic [VALUE_BITS-1:0] operand;
   logic                  cpu_idle;

   modport source (output valid, req_type, operand, cpu_idle, input ready);
   modport sink   (input valid, req_type, operand, cpu_idle, output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  saturated;

   modport source (output valid, value, saturated, input ready);
   modport sink   (input valid, value, saturated, output ready);
endinterface

interface tsc_csr_if import tsc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [VALUE_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tsc_div.sv =====
// Restoring divider, one quotient bit per cycle, with clamp to 32 bits.
// Depends on tsc_pkg.
module tsc_div import tsc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  tsc_div_req_type div_req,
   output tsc_div_rsp_type div_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic [DIVIDEND_BITS-1:0] dq_ff, dq_in;
   logic [VALUE_BITS-1:0]    rem_ff, rem_in;
   logic [VALUE_BITS-1:0]    divisor_ff, divisor_in;
   logic [VALUE_BITS:0]      trial;
   logic [VALUE_BITS:0]      diff;
   logic                     fits;

   // The shift register holds the remaining dividend bits on top and the
   // quotient bits collected so far at the bottom.
   always_comb begin
      trial = {rem_ff, dq_ff[DIVIDEND_BITS-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         dq_in      = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         dq_in   = {dq_ff[DIVIDEND_BITS-2:0], fits};
         rem_in  = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_BITS'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      div_rsp.done      = done_ff;
      div_rsp.saturated = |dq_ff[DIVIDEND_BITS-1:VALUE_BITS];
      div_rsp.value     = div_rsp.saturated ? '1 : dq_ff[VALUE_BITS-1:0];
   end

endmodule

// ===== hdl/timestamp_counter_with_unit_convert.sv =====
// Top level of the timestamp counter with unit conversion.
// Depends on tsc_pkg, the channel interfaces in tsc_if and the divider tsc_div.
//
//  Channel   Direction  Handshake        Payload
//  req_ch    in         valid / ready    req_type, operand, cpu_idle
//  rsp_ch    out        valid / ready    value, saturated
//  csr_ch    in         valid / ready    index, data (always ready)
//
// Ticks, count reads and elapsed reads complete on acceptance. A conversion is
// accepted, passes the 32 x 24 multiplier and the restoring divider (one quotient
// bit per cycle), then loads the result register. A zero clock rate skips the
// divider and answers zero in the cycle after the request is accepted.
// Reset is synchronous and clears the counter, the registers and the result slot.
// A new beat is taken only in the idle state with the result slot empty or
// draining in the same cycle, so a stalled result holds the block off.
module timestamp_counter_with_unit_convert import tsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tsc_req_if.sink    req_ch,
   tsc_rsp_if.source  rsp_ch,
   tsc_csr_if.sink    csr_ch
);

   tsc_state_type state_ff, state_in;

   // Configuration registers.
   logic                  enable_ff, enable_in;
   logic [VALUE_BITS-1:0] clock_hz_ff, clock_hz_in;
   logic                  run_in_idle_ff, run_in_idle_in;

   // The free-running counter.
   logic [COUNT_BITS-1:0] tick_count_ff, tick_count_in;

   // Conversion operands held while the multiplier and divider work.
   logic [VALUE_BITS-1:0] conv_src_ff, conv_src_in;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;

   // Result slot.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                    req_accept;
   logic                    csr_write;
   logic                    is_tick;
   logic                    is_conv;
   logic [CNT_EXT_BITS-1:0] cnt_ext;
   logic [VALUE_BITS-1:0]   count_now;
   logic [VALUE_BITS-1:0]   elapsed_now;
   tsc_div_req_type         div_req;
   tsc_div_rsp_type         div_rsp;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Only the low 32 bits of the counter are ever reported.
   assign cnt_ext     = CNT_EXT_BITS'(tick_count_ff);
   assign count_now   = enable_ff ? cnt_ext[VALUE_BITS-1:0] : '0;
   assign elapsed_now = enable_ff ? (cnt_ext[VALUE_BITS-1:0] - req_ch.operand) : '0;

   assign is_tick = (req_ch.req_type == REQ_TICK);
   assign is_conv = (req_ch.req_type inside {REQ_COUNT_US, REQ_COUNT_US10,
                                             REQ_ELAPSED_US, REQ_ELAPSED_US10});

   tsc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_conv && (clock_hz_ff != '0)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and divider launch. The product feeds the
   // divider's input register directly; both operands are widened to the
   // full 56-bit product.
   always_comb begin
      req_ch.ready     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {{SCALE_BITS{1'b0}}, conv_src_ff} *
                         {{VALUE_BITS{1'b0}}, scale_ff};
      div_req.divisor  = clock_hz_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
         end
         ST_MUL: begin
            div_req.start = 1'b1;
         end
         ST_DIV: begin
            div_req.start = 1'b0;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Datapath next values: registers, counter, conversion operands and result slot.
   always_comb begin
      enable_in      = enable_ff;
      clock_hz_in    = clock_hz_ff;
      run_in_idle_in = run_in_idle_ff;
      tick_count_in  = tick_count_ff;
      conv_src_in    = conv_src_ff;
      scale_in       = scale_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_sat_in     = rsp_sat_ff;

      if (csr_write) begin
         case (csr_ch.index)
            CSR_ENABLE: begin
               enable_in     = csr_ch.data[0];
               tick_count_in = '0;
            end
            CSR_CLOCK_HZ: begin
               clock_hz_in = csr_ch.data;
            end
            CSR_RUN_IN_IDLE: begin
               run_in_idle_in = csr_ch.data[0];
            end
            default: begin
               enable_in = enable_ff;
            end
         endcase
      end

      if (req_accept) begin
         case (req_ch.req_type)
            REQ_TICK: begin
               if (enable_ff && (!req_ch.cpu_idle || run_in_idle_ff)) begin
                  tick_count_in = tick_count_ff + 1'b1;
               end
            end
            REQ_READ_COUNT: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = count_now;
               rsp_sat_in   = 1'b0;
            end
            REQ_ELAPSED: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = elapsed_now;
               rsp_sat_in   = 1'b0;
            end
            REQ_COUNT_US, REQ_COUNT_US10, REQ_ELAPSED_US, REQ_ELAPSED_US10: begin
               conv_src_in = (req_ch.req_type inside {REQ_COUNT_US, REQ_COUNT_US10})
                             ? req_ch.operand : elapsed_now;
               scale_in    = (req_ch.req_type inside {REQ_COUNT_US, REQ_ELAPSED_US})
                             ? PER_SEC_US : PER_SEC_US10;
               // A zero clock rate answers zero at once.
               if (clock_hz_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_sat_in   = 1'b0;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
            end
         endcase
      end

      if ((state_ff == ST_DIV) && div_rsp.done) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = div_rsp.value;
         rsp_sat_in   = div_rsp.saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         enable_ff      <= 1'b0;
         clock_hz_ff    <= '0;
         run_in_idle_ff <= 1'b0;
         tick_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         enable_ff      <= enable_in;
         clock_hz_ff    <= clock_hz_in;
         run_in_idle_ff <= run_in_idle_in;
         tick_count_ff  <= tick_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      conv_src_ff  <= conv_src_in;
      scale_ff     <= scale_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.value     = rsp_value_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   // A beat is taken only while the sequencer is idle.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (state_ff == ST_IDLE))
      else $error("request beat taken while a conversion is running");

   // The divider reports a finished quotient only while the sequencer waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the wait state");

   // The counter moves only on an accepted tick or an enable write.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && is_tick) && !csr_write |=> $stable(tick_count_ff))
      else $error("counter changed without a tick or enable write");

   // A clamped result always reads as all ones.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_value_ff == '1))
      else $error("saturated result is not all ones");

   // A conversion result never lands on a result that is still waiting.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && div_rsp.done) |-> !rsp_valid_ff)
      else $error("conversion result overwrote a pending result");

endmodule
